// ----- rtl/core/gbfg_pkg.sv -----
`timescale 1ns / 1ps
package gbfg_pkg;
  localparam logic [1:0] CFG_START = 2'd0;
  localparam logic [1:0] CFG_END   = 2'd1;
  localparam logic [1:0] CFG_HORIZ = 2'd2;
  localparam logic [23:0] RED_MASK   = 24'hFF0000;
  localparam logic [23:0] GREEN_MASK = 24'h00FF00;
  localparam logic [23:0] BLUE_MASK  = 24'h0000FF;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV1, ST_DIV2, ST_DIV3, ST_DLT, ST_DEN, ST_PER, ST_EMIT, ST_NEXT
  } state_t;

  // divider command/status
  typedef struct packed {
    logic        go;
    logic [16:0] num;
    logic [16:0] den;
  } div_cmd_t;

  typedef struct packed {
    logic        done;
    logic [16:0] quo;
  } div_sts_t;
endpackage

// ----- rtl/core/gradient_band_fill_generator_unit.sv -----
`timescale 1ns / 1ps
// Gradient band generator for a 2D fill engine.
// Configuration: cfg_we with cfg_index (0 start colour, 1 end colour,
// 2 horizontal) and cfg_data, written only while idle; taken at once.
// Input: an item is taken when start is high and busy is low. in_req_type 0
// starts a gradient on the rectangle, 1 asks for the next band.
// Output: one item per input item, on the out_ ports for a single cycle,
// marked by out_strobe. The receiver cannot stall the block.
// Sequence: a start runs 12 divisions on one shared restoring divider (band
// count fit, band size, then delta, rest and period for each channel), one
// after another, and its result register is loaded after the last. A next
// item passes decode, emit with the colour/position update, and the result
// register. Only one item is held at a time; busy drops in the result cycle.
// Reset (synchronous, rst_n low) clears the sequencer and the gradient;
// a next item before any start returns an all-zero band.
module gradient_band_fill_generator_unit import gbfg_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [15:0] in_rect_left,
  input  logic [15:0] in_rect_top,
  input  logic [15:0] in_rect_width,
  input  logic [15:0] in_rect_height,
  output logic        out_strobe,
  output logic        out_band_valid,
  output logic [16:0] out_fill_x,
  output logic [16:0] out_fill_y,
  output logic [15:0] out_fill_w,
  output logic [15:0] out_fill_h,
  output logic [23:0] out_band_color,
  output logic        out_last_band
);
  localparam logic [15:0] CMASK = 16'((17'd1 << COORD_BITS) - 17'd1);

  logic [23:0] scol_r, ecol_r;
  logic        hcfg_r;

  state_t st_r, st_nxt;
  logic        gbusy_r, gbusy_nxt, hz_r, hz_nxt;
  logic [7:0]  total_r, total_nxt, idx_r, idx_nxt;
  logic [15:0] size_r, size_nxt;
  logic [16:0] pos_r, pos_nxt;
  logic [15:0] rl_r, rt_r, rw_r, rh_r, rl_nxt, rt_nxt, rw_nxt, rh_nxt;
  logic [7:0]  now_r [3], now_nxt [3], tgt_r [3], tgt_nxt [3];
  logic [7:0]  dlt_r [3], dlt_nxt [3], per_r [3], per_nxt [3];
  logic [7:0]  dif_r [3], dif_nxt [3];
  logic [7:0]  mod_r [3], mod_nxt [3];
  logic [2:0]  rise_r, rise_nxt;
  logic [16:0] step_r, step_nxt, q_r, q_nxt, ext_r, ext_nxt;
  logic [1:0]  ch_r, ch_nxt;
  logic        nul_r, nul_nxt;

  div_cmd_t dcmd;
  div_sts_t dsts;
  gbfg_div u_div (.clk(clk), .rst_n(rst_n), .cmd(dcmd), .sts(dsts));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scol_r <= '0; ecol_r <= '0; hcfg_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START: scol_r <= cfg_data;
        CFG_END:   ecol_r <= cfg_data;
        CFG_HORIZ: hcfg_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic take;
  assign busy = (st_r != ST_IDLE);
  assign take = start && !busy;

  logic [7:0] sc [3], ec [3];
  assign sc[0] = 8'((scol_r & RED_MASK) >> 16);
  assign sc[1] = 8'((scol_r & GREEN_MASK) >> 8);
  assign sc[2] = 8'(scol_r & BLUE_MASK);
  assign ec[0] = 8'((ecol_r & RED_MASK) >> 16);
  assign ec[1] = 8'((ecol_r & GREEN_MASK) >> 8);
  assign ec[2] = 8'(ecol_r & BLUE_MASK);

  logic last;
  assign last = ({1'b0, idx_r} + 9'd1) >= {1'b0, total_r};

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (take) st_nxt = in_req_type ? ST_NEXT : ST_DIV1;
      ST_DIV1: if (dsts.done) st_nxt = ST_DIV2;
      ST_DIV2: if (dsts.done) st_nxt = ST_DIV3;
      ST_DIV3: if (dsts.done) st_nxt = ST_DLT;
      ST_DLT:  if (dsts.done) st_nxt = ST_DEN;
      ST_DEN:  if (dsts.done) st_nxt = ST_PER;
      ST_PER:  if (dsts.done) st_nxt = (ch_r == 2'd2) ? ST_EMIT : ST_DLT;
      ST_NEXT: st_nxt = ST_EMIT;
      ST_EMIT: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  logic [16:0] tw;
  logic [16:0] qt;

  always_comb begin
    gbusy_nxt = gbusy_r; hz_nxt = hz_r; total_nxt = total_r; idx_nxt = idx_r;
    size_nxt = size_r; pos_nxt = pos_r;
    rl_nxt = rl_r; rt_nxt = rt_r; rw_nxt = rw_r; rh_nxt = rh_r;
    now_nxt = now_r; tgt_nxt = tgt_r; dlt_nxt = dlt_r; per_nxt = per_r;
    dif_nxt = dif_r; rise_nxt = rise_r; mod_nxt = mod_r;
    step_nxt = step_r; q_nxt = q_r; ext_nxt = ext_r; ch_nxt = ch_r;
    nul_nxt = nul_r;
    dcmd = '0;
    tw = '0; qt = dsts.quo;
    unique case (st_r)
      ST_IDLE: begin
        if (take && !in_req_type) begin
          rl_nxt = in_rect_left & CMASK; rt_nxt = in_rect_top & CMASK;
          rw_nxt = in_rect_width & CMASK; rh_nxt = in_rect_height & CMASK;
          hz_nxt = hcfg_r;
          tw = '0;
          for (int k = 0; k < 3; k++) begin
            rise_nxt[k] = !(sc[k] > ec[k]);
            dif_nxt[k] = rise_nxt[k] ? ec[k] - sc[k] : sc[k] - ec[k];
            if ({9'd0, dif_nxt[k]} > tw) tw = {9'd0, dif_nxt[k]};
            now_nxt[k] = sc[k]; tgt_nxt[k] = ec[k];
            dlt_nxt[k] = '0; per_nxt[k] = '0;
          end
          ext_nxt = {1'b0, hcfg_r ? rw_nxt : rh_nxt};
          if (tw > ext_nxt) tw = ext_nxt;
          nul_nxt = (tw == '0);
          step_nxt = (tw == '0) ? 17'd1 : tw;
          ch_nxt = '0;
          dcmd.go = 1'b1; dcmd.num = ext_nxt; dcmd.den = step_nxt;
        end
      end
      ST_DIV1: if (dsts.done) begin
        // ext/step; exact fit keeps step, otherwise ext/(q+1)
        q_nxt = qt;
        dcmd.go = 1'b1; dcmd.num = ext_r;
        if (nul_r || (17'(qt * step_r) == ext_r)) dcmd.den = step_r;
        else dcmd.den = qt + 17'd1;
      end
      ST_DIV2: if (dsts.done) begin
        if (!(nul_r || (17'(q_r * step_r) == ext_r)))
          step_nxt = (qt == '0) ? 17'd1 : qt;
        dcmd.go = 1'b1; dcmd.num = ext_r;
        dcmd.den = (!(nul_r || (17'(q_r * step_r) == ext_r)) && qt == '0) ?
                   17'd1 : ((!(nul_r || (17'(q_r * step_r) == ext_r))) ? qt : step_r);
      end
      ST_DIV3: if (dsts.done) begin
        size_nxt = qt[15:0];
        total_nxt = (step_r[7:0] == 8'd0) ? 8'd1 : step_r[7:0];
        pos_nxt = {1'b0, hz_r ? rl_r : rt_r};
        idx_nxt = '0; gbusy_nxt = 1'b1;
        for (int k = 0; k < 3; k++) mod_nxt[k] = '0;
        dcmd.go = 1'b1; dcmd.num = {9'd0, dif_r[0]}; dcmd.den = step_r;
      end
      ST_DLT: if (dsts.done) begin
        if (step_r > 17'd1) dlt_nxt[ch_r] = (qt == '0) ? 8'd1 : qt[7:0];
        dcmd.go = 1'b1;
        dcmd.num = 17'({9'd0, dif_r[ch_r]} - step_r);
        dcmd.den = {9'd0, (qt == '0) ? 8'd1 : qt[7:0]};
      end
      ST_DEN: if (dsts.done) begin
        dcmd.go = 1'b1; dcmd.num = step_r;
        dcmd.den = (qt == '0) ? 17'd1 : qt;
        if (step_r > 17'd1 && {9'd0, dif_r[ch_r]} > step_r && qt != '0)
          nul_nxt = 1'b0;
        else
          nul_nxt = 1'b1;
      end
      ST_PER: if (dsts.done) begin
        if (!nul_r) per_nxt[ch_r] = qt[7:0];
        if (ch_r != 2'd2) begin
          ch_nxt = ch_r + 2'd1;
          dcmd.go = 1'b1; dcmd.num = {9'd0, dif_r[ch_r + 2'd1]}; dcmd.den = step_r;
        end
      end
      ST_EMIT: begin
        if (gbusy_r) begin
          if (last) gbusy_nxt = 1'b0;
          else begin
            pos_nxt = pos_r + {1'b0, size_r};
            for (int k = 0; k < 3; k++) begin
              mod_nxt[k] = (mod_r[k] + 8'd1 == per_r[k]) ? 8'd0 : mod_r[k] + 8'd1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // next-band colour update; mod_r tracks band index modulo rest period, with a
  // nonzero period a zero count on a nonzero index applies the delta a second time
  logic [2:0] twice;
  logic [9:0] ws [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      twice[k] = (idx_r != '0) && (per_r[k] != '0) && (mod_r[k] == '0);
      if (rise_r[k])
        ws[k] = {2'b0, now_r[k]} + {2'b0, dlt_r[k]} + (twice[k] ? {2'b0, dlt_r[k]} : 10'd0);
      else
        ws[k] = {2'b0, now_r[k]} - {2'b0, dlt_r[k]} - (twice[k] ? {2'b0, dlt_r[k]} : 10'd0);
    end
  end

  logic upd;
  assign upd = (st_r == ST_EMIT) && gbusy_r && !last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; gbusy_r <= 1'b0; total_r <= 8'd1; idx_r <= '0;
      size_r <= '0; pos_r <= '0; rl_r <= '0; rt_r <= '0; rw_r <= '0; rh_r <= '0;
      rise_r <= '0; hz_r <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        now_r[k] <= '0; dlt_r[k] <= '0; per_r[k] <= '0; tgt_r[k] <= '0;
        mod_r[k] <= '0;
      end
    end else begin
      st_r <= st_nxt; gbusy_r <= gbusy_nxt; total_r <= total_nxt;
      size_r <= size_nxt; pos_r <= pos_nxt; hz_r <= hz_nxt;
      rl_r <= rl_nxt; rt_r <= rt_nxt; rw_r <= rw_nxt; rh_r <= rh_nxt;
      rise_r <= rise_nxt; dlt_r <= dlt_nxt; per_r <= per_nxt; tgt_r <= tgt_nxt;
      mod_r <= mod_nxt;
      idx_r <= upd ? idx_nxt + 8'd1 : idx_nxt;
      for (int k = 0; k < 3; k++) begin
        if (upd) begin
          if (rise_r[k]) now_r[k] <= ($signed(ws[k]) > $signed({2'b0, tgt_r[k]})) ?
                                     tgt_r[k] : ws[k][7:0];
          else now_r[k] <= ($signed(ws[k]) < $signed({2'b0, tgt_r[k]})) ?
                           tgt_r[k] : ws[k][7:0];
        end else now_r[k] <= now_nxt[k];
      end
    end
    dif_r <= dif_nxt; step_r <= step_nxt; q_r <= q_nxt; ext_r <= ext_nxt;
    ch_r <= ch_nxt; nul_r <= nul_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe <= 1'b0;
    else out_strobe <= (st_r == ST_EMIT);
    if (st_r == ST_EMIT) begin
      out_band_valid <= gbusy_r;
      out_last_band  <= gbusy_r && last;
      out_band_color <= gbusy_r ? {now_r[0], now_r[1], now_r[2]} : 24'd0;
      if (!gbusy_r) begin
        out_fill_x <= '0; out_fill_y <= '0; out_fill_w <= '0; out_fill_h <= '0;
      end else if (hz_r) begin
        out_fill_x <= pos_r; out_fill_y <= {1'b0, rt_r}; out_fill_h <= rh_r;
        out_fill_w <= last ? 16'({1'b0, rw_r} + {1'b0, rl_r} - pos_r) : size_r;
      end else begin
        out_fill_x <= {1'b0, rl_r}; out_fill_y <= pos_r; out_fill_w <= rw_r;
        out_fill_h <= last ? 16'({1'b0, rh_r} + {1'b0, rt_r} - pos_r) : size_r;
      end
    end
  end
endmodule

// ----- rtl/core/gbfg_div.sv -----
`timescale 1ns / 1ps
module gbfg_div import gbfg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_cmd_t cmd,
  output div_sts_t sts
);
  // restoring divider, one quotient bit a cycle
  logic [16:0] rem_r, rem_nxt, quo_r, quo_nxt, den_r, den_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        act_r, act_nxt, done_r, done_nxt;
  logic [17:0] trial;

  always_comb begin
    rem_nxt = rem_r; quo_nxt = quo_r; den_nxt = den_r;
    cnt_nxt = cnt_r; act_nxt = act_r; done_nxt = 1'b0;
    trial = {rem_r, quo_r[16]} - {1'b0, den_r};
    if (cmd.go) begin
      rem_nxt = '0; quo_nxt = cmd.num; den_nxt = cmd.den;
      cnt_nxt = 5'd17; act_nxt = 1'b1;
    end else if (act_r) begin
      if (!trial[17]) begin
        rem_nxt = trial[16:0];
        quo_nxt = {quo_r[15:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[15:0], quo_r[16]};
        quo_nxt = {quo_r[15:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        act_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      act_r <= act_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt; quo_r <= quo_nxt; den_r <= den_nxt;
  end

  assign sts.done = done_r;
  assign sts.quo  = quo_r;
endmodule

// ----- dv/tb_gradient_band_fill_generator_unit.sv -----
`timescale 1ns / 1ps
module tb_gradient_band_fill_generator_unit;
  import gbfg_pkg::*;

  // The slowest item is a start. The sender's longest gap is MAX_GAP, and
  // the watchdog only counts cycles in which nothing is taken.
  localparam int IDLE_LIMIT = 4000;

  // Sender idling between bursts: burst length and gap.
  localparam int MAX_GAP   = 40;
  localparam int MAX_BURST = 12;

  typedef struct packed {
    logic        band_valid;
    logic [16:0] fill_x;
    logic [16:0] fill_y;
    logic [15:0] fill_w;
    logic [15:0] fill_h;
    logic [23:0] band_color;
    logic        last_band;
  } band_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;
  logic        start;
  logic        busy;
  logic        in_req_type;
  logic [15:0] in_rect_left;
  logic [15:0] in_rect_top;
  logic [15:0] in_rect_width;
  logic [15:0] in_rect_height;
  logic        out_strobe;
  logic        out_band_valid;
  logic [16:0] out_fill_x;
  logic [16:0] out_fill_y;
  logic [15:0] out_fill_w;
  logic [15:0] out_fill_h;
  logic [23:0] out_band_color;
  logic        out_last_band;

  gradient_band_fill_generator_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_rect_left  (in_rect_left),
    .in_rect_top   (in_rect_top),
    .in_rect_width (in_rect_width),
    .in_rect_height(in_rect_height),
    .out_strobe    (out_strobe),
    .out_band_valid(out_band_valid),
    .out_fill_x    (out_fill_x),
    .out_fill_y    (out_fill_y),
    .out_fill_w    (out_fill_w),
    .out_fill_h    (out_fill_h),
    .out_band_color(out_band_color),
    .out_last_band (out_last_band)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---- shadow of the configuration registers ----
  logic [23:0] cfg_from_col;
  logic [23:0] cfg_to_col;
  logic        cfg_horiz;

  // ---- predicted gradient state ----
  logic        grad_running;
  logic [7:0]  band_count;
  logic [7:0]  band_no;
  logic [15:0] band_len;
  logic [16:0] band_pos;
  logic [15:0] rect_l, rect_t, rect_w, rect_h;
  logic        along_x;
  int          chan_val[3];
  int          chan_step[3];
  int          chan_period[3];
  logic        chan_up[3];
  int          chan_goal[3];

  band_t bands_due[$];
  int    fail_count;
  int    items_sent;
  int    bands_seen;
  int    last_bands_seen;
  int    idle_cycles;
  logic  timed_out;
  int    burst_left;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Next band from the held gradient; advances position and colour unless it is the last band.
  function automatic band_t emit_next_band();
    band_t   b;
    logic    fin;
    int      v;
    logic    twice;
    b = '0;
    fin = (32'(band_no) + 1 >= 32'(band_count));
    b.band_valid = 1'b1;
    if (along_x) begin
      b.fill_x = band_pos;
      b.fill_y = {1'b0, rect_t};
      b.fill_w = fin ? 16'(32'(rect_w) + 32'(rect_l) - 32'(band_pos)) : band_len;
      b.fill_h = rect_h;
    end else begin
      b.fill_x = {1'b0, rect_l};
      b.fill_y = band_pos;
      b.fill_w = rect_w;
      b.fill_h = fin ? 16'(32'(rect_h) + 32'(rect_t) - 32'(band_pos)) : band_len;
    end
    b.band_color = {chan_val[0][7:0], chan_val[1][7:0], chan_val[2][7:0]};
    b.last_band = fin;
    if (fin) begin
      grad_running = 1'b0;
      return b;
    end
    band_pos = 17'(32'(band_pos) + 32'(band_len));
    for (int k = 0; k < 3; k++) begin
      v = chan_val[k];
      twice = (band_no != 0) && (chan_period[k] != 0) &&
              ((int'(band_no) % chan_period[k]) == 0);
      if (chan_up[k]) begin
        v += chan_step[k];
        if (twice) v += chan_step[k];
        if (v > chan_goal[k]) v = chan_goal[k];
      end else begin
        v -= chan_step[k];
        if (twice) v -= chan_step[k];
        if (v < chan_goal[k]) v = chan_goal[k];
      end
      chan_val[k] = v;
    end
    band_no = band_no + 8'd1;
    return b;
  endfunction

  // Plans a new gradient on the rectangle and returns its first band.
  function automatic band_t plan_gradient(input logic [15:0] l, t, w, h);
    int from[3];
    int dif[3];
    int ext, stp, q, d, den;
    rect_l = l; rect_t = t; rect_w = w; rect_h = h;
    along_x = cfg_horiz;
    from[0] = int'(cfg_from_col[23:16]);
    from[1] = int'(cfg_from_col[15:8]);
    from[2] = int'(cfg_from_col[7:0]);
    chan_goal[0] = int'(cfg_to_col[23:16]);
    chan_goal[1] = int'(cfg_to_col[15:8]);
    chan_goal[2] = int'(cfg_to_col[7:0]);
    stp = 0;
    for (int k = 0; k < 3; k++) begin
      chan_up[k] = !(from[k] > chan_goal[k]);
      dif[k] = chan_up[k] ? chan_goal[k] - from[k] : from[k] - chan_goal[k];
      if (dif[k] > stp) stp = dif[k];
    end
    ext = along_x ? int'(w) : int'(h);
    if (stp > ext) stp = ext;
    if (stp == 0) begin
      stp = 1;
    end else begin
      q = ext / stp;
      if (ext != q * stp) begin
        stp = ext / (q + 1);
        if (stp > ext) stp = ext;
        if (stp == 0) stp = 1;
      end
    end
    for (int k = 0; k < 3; k++) begin
      chan_step[k] = 0;
      chan_period[k] = 0;
      if (stp > 1) begin
        d = dif[k] / stp;
        if (d == 0) d = 1;
        chan_step[k] = d;
        if (dif[k] > stp) begin
          den = (dif[k] - stp) / d;
          if (den > 0) chan_period[k] = stp / den;
        end
      end
      chan_val[k] = from[k];
    end
    band_count = 8'(stp);
    if (band_count == 0) band_count = 8'd1;
    band_len = 16'(ext / stp);
    band_pos = along_x ? {1'b0, l} : {1'b0, t};
    band_no = 8'd0;
    grad_running = 1'b1;
    return emit_next_band();
  endfunction

  // Register write, only while idle; updates the shadow copy, then idles past the write.
  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_START: cfg_from_col = val;
      CFG_END:   cfg_to_col = val;
      CFG_HORIZ: cfg_horiz = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Sends one item; sender idles in bursts with random gaps.
  task automatic send_item(input logic kind, input logic [15:0] l, t, w, h);
    int gap;
    // the block is busy for the edge after any accept, so this costs no rate
    @(posedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(MAX_BURST, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(MAX_GAP, 1);
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    start <= 1'b1;
    in_req_type <= kind;
    in_rect_left <= l;
    in_rect_top <= t;
    in_rect_width <= w;
    in_rect_height <= h;
    do @(posedge clk); while (busy);
    if (kind) bands_due.push_back(grad_running ? emit_next_band() : band_t'('0));
    else bands_due.push_back(plan_gradient(l, t, w, h));
    items_sent++;
    start <= 1'b0;
  endtask

  task automatic send_next();
    send_item(1'b1, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic drain_all();
    while (bands_due.size() != 0 && !timed_out) @(posedge clk);
    // A band count of zero cannot happen, but let the update step settle.
    repeat (8) @(posedge clk);
  endtask

  // Result checker: outputs sampled at the edge ending the strobe cycle.
  always @(posedge clk) begin
    band_t want, got;
    if (rst_n && out_strobe) begin
      got = {out_band_valid, out_fill_x, out_fill_y, out_fill_w, out_fill_h,
             out_band_color, out_last_band};
      bands_seen++;
      if (out_last_band) last_bands_seen++;
      if (bands_due.size() == 0) begin
        $display("unexpected band item at %0t", $realtime);
        fail_count++;
      end else begin
        want = bands_due.pop_front();
        if (got.band_valid !== want.band_valid)
          report_mismatch("band_valid", 32'(got.band_valid), 32'(want.band_valid));
        if (got.fill_x !== want.fill_x)
          report_mismatch("fill_x", 32'(got.fill_x), 32'(want.fill_x));
        if (got.fill_y !== want.fill_y)
          report_mismatch("fill_y", 32'(got.fill_y), 32'(want.fill_y));
        if (got.fill_w !== want.fill_w)
          report_mismatch("fill_w", 32'(got.fill_w), 32'(want.fill_w));
        if (got.fill_h !== want.fill_h)
          report_mismatch("fill_h", 32'(got.fill_h), 32'(want.fill_h));
        if (got.band_color !== want.band_color)
          report_mismatch("band_color", 32'(got.band_color), 32'(want.band_color));
        if (got.last_band !== want.last_band)
          report_mismatch("last_band", 32'(got.last_band), 32'(want.last_band));
      end
    end
  end

  // Watchdog: cycles with no item taken in either direction.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog expired, %0d band items outstanding", bands_due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---- tests ----

  // Next items before any start give all-zero bands.
  task automatic test_next_before_start();
    repeat (2) send_next();
  endtask

  // Extremes of rectangle and colours, both directions.
  task automatic test_directed();
    drain_all();
    write_reg(CFG_START, 24'h000000);
    write_reg(CFG_END, 24'hFFFFFF);
    write_reg(CFG_HORIZ, 24'd1);
    send_item(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (3) send_next();
    // restart while running: old gradient dropped
    send_item(1'b0, 16'd10, 16'd20, 16'd7, 16'd5);
    repeat (8) send_next(); // runs past the last band
    drain_all();
    write_reg(CFG_START, 24'hFF80FF);
    write_reg(CFG_END, 24'h00C001);
    write_reg(CFG_HORIZ, 24'd0);
    send_item(1'b0, 16'h0000, 16'hFFF0, 16'd3, 16'd1000);
    repeat (4) send_next();
    // zero extent
    send_item(1'b0, 16'd5, 16'd5, 16'd100, 16'd0);
    send_next();
    drain_all();
    // equal colours: one band
    write_reg(CFG_END, 24'hFF80FF);
    send_item(1'b0, 16'd1, 16'd2, 16'd50, 16'd60);
    send_next();
    // colour writes after a start only affect the next start
    send_item(1'b0, 16'd0, 16'd0, 16'd9, 16'd40);
    drain_all();
    write_reg(CFG_END, 24'h123456);
    send_next();
    drain_all();
  endtask

  // Random gradients: mostly start then a run of nexts, some broken sequences.
  task automatic test_random_gradients();
    logic [15:0] ext_w, ext_h;
    int          runs;
    while (items_sent < 710 && !timed_out) begin
      if ($urandom_range(4, 0) == 0) begin
        drain_all();
        write_reg(CFG_START, 24'($urandom));
        write_reg(CFG_END, ($urandom_range(5, 0) == 0) ? cfg_from_col : 24'($urandom));
        write_reg(CFG_HORIZ, 24'($urandom_range(1, 0)));
      end
      // mostly small extents so gradients finish; a few full-range ones
      ext_w = ($urandom_range(9, 0) == 0) ? 16'($urandom) : 16'($urandom_range(80, 0));
      ext_h = ($urandom_range(9, 0) == 0) ? 16'($urandom) : 16'($urandom_range(80, 0));
      send_item(1'b0, 16'($urandom), 16'($urandom), ext_w, ext_h);
      runs = ($urandom_range(3, 0) == 0) ? $urandom_range(6, 0) : $urandom_range(40, 5);
      repeat (runs) send_next();
      // now and then: pause until every band has come back
      if ($urandom_range(7, 0) == 0) drain_all();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = CFG_START; cfg_data = '0;
    start = 1'b0; in_req_type = 1'b0;
    in_rect_left = '0; in_rect_top = '0; in_rect_width = '0; in_rect_height = '0;
    cfg_from_col = '0; cfg_to_col = '0; cfg_horiz = 1'b0;
    grad_running = 1'b0; band_count = 8'd1; band_no = '0; band_len = '0;
    band_pos = '0; along_x = 1'b0;
    fail_count = 0; items_sent = 0; bands_seen = 0; last_bands_seen = 0;
    idle_cycles = 0; timed_out = 1'b0; burst_left = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_next_before_start();
    test_directed();
    drain_all();
    test_random_gradients();
    drain_all();
    $display("%0d items sent, %0d bands checked, %0d gradients run to their end",
             items_sent, bands_seen, last_bands_seen);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/gbfg_pkg.sv
rtl/core/gbfg_div.sv
rtl/core/gradient_band_fill_generator_unit.sv
dv/tb_gradient_band_fill_generator_unit.sv
